@@ hw/rtl/pip_pkg.sv @@
// Shared types, constants and helpers for the point-in-polygon test block.
// Used by pip_mul and point_in_polygon_test; depends on nothing else.
package pip_pkg;

    // Polygon storage and coordinate sizing.
    localparam int MAX_VERTICES = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int FIELD_W      = 16;
    localparam int CFG_W        = 5;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CW_EFF       = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int DIFF_W       = FIELD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int MIN_VERTICES = 3;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Input word of the command channel.
    typedef struct packed {
        logic                      req_type;
        logic [3:0]                vertex_index;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
    } t_pip_req;

    // Result word.
    typedef struct packed {
        logic inside_res;
        logic on_boundary;
    } t_pip_res;

    // One stored vertex.
    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
    } t_pip_vtx;

    // Query sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_EDGE,
        S_MUL1,
        S_MUL2,
        S_ACC
    } t_pip_state;

    // Reduce a coordinate to the configured coordinate width, sign extended.
    function automatic logic signed [FIELD_W-1:0] coord_in(input logic signed [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] t;
        t = v <<< (FIELD_W - CW_EFF);
        return t >>> (FIELD_W - CW_EFF);
    endfunction

endpackage

@@ hw/rtl/pip_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on pip_pkg for operand and product widths.
module pip_mul (
    input  logic                              i_clk,
    input  logic signed [pip_pkg::DIFF_W-1:0] i_a,
    input  logic signed [pip_pkg::DIFF_W-1:0] i_b,
    output logic signed [pip_pkg::PROD_W-1:0] o_p
);
    import pip_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    // One product per cycle, registered before use.
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ hw/rtl/point_in_polygon_test.sv @@
// Top level of the point-in-polygon test: vertex store, query sequencer, result port.
// Depends on pip_pkg and instantiates pip_mul.
//
// A load word (start high while busy is low) writes one vertex and gives no result;
// busy stays low. A query word raises busy and walks the polygon edge by edge,
// reading one vertex per edge from the store and running two products of one
// shared 17x17 multiplier per edge. The result appears on o_res for exactly one
// cycle with o_res_valid high; the receiver cannot stall it, and a new word may be
// started in that same cycle. The vertex count register is written through its own
// valid/ready port, which is ready whenever the block is not busy.
module point_in_polygon_test (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  pip_pkg::t_pip_req         i_req,
    output logic                      o_res_valid,
    output pip_pkg::t_pip_res         o_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pip_pkg::CFG_W-1:0] i_cfg_data
);
    import pip_pkg::*;

    // Control state.
    t_pip_state       r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CFG_W-1:0] r_cfg, n_cfg;
    logic             r_onb, n_onb;
    logic             r_inside, n_inside;
    logic             r_res_valid, n_res_valid;
    t_pip_res         r_res, n_res;

    // Datapath registers.
    t_pip_vtx                  r_mem [MAX_VERTICES];
    t_pip_vtx                  r_rd;
    t_pip_vtx                  r_first;
    t_pip_vtx                  r_a;
    logic signed [FIELD_W-1:0] r_px, r_py;
    logic signed [DIFF_W-1:0]  r_ex, r_ey, r_dx, r_dy;
    logic                      r_bbox, r_straddle, r_den_pos, r_last;
    logic signed [PROD_W-1:0]  r_p1;

    logic                      w_accept, w_load, w_query, w_cfg_wr;
    logic [VIDX_W-1:0]         w_rd_addr;
    t_pip_vtx                  w_b;
    logic signed [DIFF_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [CROSS_W-1:0] w_cross;
    logic                      w_hit;
    logic signed [FIELD_W-1:0] w_qx, w_qy;

    // Handshakes.
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign w_accept    = start && !busy;
    assign w_load      = w_accept && (i_req.req_type == REQ_LOAD);
    assign w_query     = w_accept && (i_req.req_type == REQ_QUERY);
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_qx        = coord_in(i_req.coord_x);
    assign w_qy        = coord_in(i_req.coord_y);

    // Vertex store: one write port for loads, one registered read port for the walk.
    assign w_rd_addr = (r_state == S_IDLE) ? '0 : r_k[VIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_load && (int'(i_req.vertex_index) < MAX_VERTICES)) begin
            r_mem[i_req.vertex_index[VIDX_W-1:0]] <= '{x: w_qx, y: w_qy};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Far end of the current edge wraps back to the first vertex.
    assign w_b = (r_k == r_n) ? r_first : r_rd;

    // Shared multiplier: edge x times point dy, then edge y times point dx.
    assign w_mul_a = (r_state == S_MUL1) ? r_ex : r_ey;
    assign w_mul_b = (r_state == S_MUL1) ? r_dy : r_dx;

    pip_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // The cross product decides both the collinear test and the crossing side.
    assign w_cross = CROSS_W'(r_p1) - CROSS_W'(w_prod);
    assign w_hit   = r_straddle && (r_den_pos ? (w_cross < 0) : (w_cross > 0));

    // Edge operands, point and first vertex.
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= w_qx;
            r_py <= w_qy;
        end
        if (r_state == S_FIRST) begin
            r_first <= r_rd;
            r_a     <= r_rd;
        end
        if (r_state == S_EDGE) begin
            r_ex       <= DIFF_W'(w_b.x) - DIFF_W'(r_a.x);
            r_ey       <= DIFF_W'(w_b.y) - DIFF_W'(r_a.y);
            r_dx       <= DIFF_W'(r_px) - DIFF_W'(r_a.x);
            r_dy       <= DIFF_W'(r_py) - DIFF_W'(r_a.y);
            r_bbox     <= ((r_px >= r_a.x) || (r_px >= w_b.x))
                       && ((r_px <= r_a.x) || (r_px <= w_b.x))
                       && ((r_py >= r_a.y) || (r_py >= w_b.y))
                       && ((r_py <= r_a.y) || (r_py <= w_b.y));
            r_straddle <= (w_b.y > r_py) != (r_a.y > r_py);
            r_den_pos  <= (w_b.y < r_a.y);
            r_last     <= (r_k == r_n);
            r_a        <= w_b;
        end
        if (r_state == S_MUL2) begin
            r_p1 <= w_prod;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_n         <= CNT_W'(MIN_VERTICES);
            r_cfg       <= CFG_W'(MIN_VERTICES);
            r_onb       <= 1'b0;
            r_inside    <= 1'b0;
            r_res_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_n         <= n_n;
            r_cfg       <= n_cfg;
            r_onb       <= n_onb;
            r_inside    <= n_inside;
            r_res_valid <= n_res_valid;
            r_res       <= n_res;
        end
    end

    // Sequencer: next state and control updates.
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_n         = r_n;
        n_cfg       = w_cfg_wr ? i_cfg_data : r_cfg;
        n_onb       = r_onb;
        n_inside    = r_inside;
        n_res_valid = 1'b0;
        n_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state  = S_FIRST;
                    n_k      = CNT_W'(1);
                    n_onb    = 1'b0;
                    n_inside = 1'b0;
                    if (int'(r_cfg) < MIN_VERTICES) begin
                        n_n = CNT_W'(MIN_VERTICES);
                    end else if (int'(r_cfg) > MAX_VERTICES) begin
                        n_n = CNT_W'(MAX_VERTICES);
                    end else begin
                        n_n = CNT_W'(r_cfg);
                    end
                end
            end
            S_FIRST: begin
                n_state = S_EDGE;
            end
            S_EDGE: begin
                n_state = S_MUL1;
                n_k     = r_k + CNT_W'(1);
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if ((w_cross == 0) && r_bbox) begin
                    n_onb = 1'b1;
                end
                if (w_hit) begin
                    n_inside = !r_inside;
                end
                if (r_last) begin
                    n_state           = S_IDLE;
                    n_res_valid       = 1'b1;
                    n_res.on_boundary = n_onb;
                    n_res.inside_res  = n_onb || n_inside;
                end else begin
                    n_state = S_EDGE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // A result strobe only follows the last edge of a walk.
    a_res_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(r_state) == S_ACC) && $past(r_last))
        else $error("result strobe without a finished edge walk");

    // A boundary point is always reported inside.
    a_boundary_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (!o_res.on_boundary || o_res.inside_res))
        else $error("boundary result not marked inside");

    // The active vertex count stays clamped during a walk.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (int'(r_n) >= MIN_VERTICES) && (int'(r_n) <= MAX_VERTICES))
        else $error("active vertex count out of range");

    // The edge counter stays nonzero and never runs more than one past the vertex count.
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_k <= r_n + CNT_W'(1)) && (r_k != '0))
        else $error("edge counter out of range");

    // A query word starts the walk on the next cycle.
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> (r_state == S_FIRST))
        else $error("query word did not start a walk");

endmodule
